@@ sv/dual_wheel_encoder_pd_speed_control_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the wheel speed control block
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_ENCODER_PD_SPEED_CONTROL_MACROS_SVH
`define DUAL_WHEEL_ENCODER_PD_SPEED_CONTROL_MACROS_SVH

// implication checked at the same edge
`define DWSC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dwsc assertion failed");

// implication checked at the next edge
`define DWSC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dwsc assertion failed");

`endif

@@ sv/dwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dwsc_pkg
// Shared types and constants of the dual wheel speed control block
// ----------------------------------------------------------------------------
package dwsc_pkg;

  // request kinds carried in tuser
  localparam logic [1:0] REQ_LEFT_EDGE  = 2'd0;
  localparam logic [1:0] REQ_RIGHT_EDGE = 2'd1;
  localparam logic [1:0] REQ_TICK       = 2'd2;

  // configuration register map
  localparam int         CFG_ADDR_W     = 8;
  localparam int         CFG_DATA_W     = 16;
  localparam logic [7:0] REG_GAIN_P     = 8'd0;
  localparam logic [7:0] REG_GAIN_D     = 8'd1;
  localparam logic [7:0] REG_SET_LEFT   = 8'd2;
  localparam logic [7:0] REG_SET_RIGHT  = 8'd3;

  // drive accumulator, signed Q8.8
  localparam int ACC_W       = 17;
  localparam int DRIVE_LIMIT = 65280;

  // edge counter control
  typedef struct packed {
    logic step;
    logic up;
    logic clear;
  } edge_ctl_t;

endpackage

@@ sv/dwsc_edge_counter.sv @@
// ----------------------------------------------------------------------------
// dwsc_edge_counter
// Saturating signed encoder edge counter, cleared by the control tick
// ----------------------------------------------------------------------------
`include "dual_wheel_encoder_pd_speed_control_macros.svh"

module dwsc_edge_counter #(
  parameter int COUNT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dwsc_pkg::edge_ctl_t          ctl,
  output logic signed [COUNT_BITS-1:0] count
);
  import dwsc_pkg::*;

  localparam logic signed [COUNT_BITS-1:0] LIM_POS = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] LIM_NEG =
    {1'b1, {(COUNT_BITS-2){1'b0}}, 1'b1};

  logic signed [COUNT_BITS-1:0] count_next;

  // clear to zero, else step toward the limit and hold at it
  always_comb begin
    count_next = count;
    priority if (ctl.clear) begin
      count_next = '0;
    end else if (ctl.step) begin
      if (ctl.up) begin
        if (count != LIM_POS) count_next = count + COUNT_BITS'(1);
      end else begin
        if (count != LIM_NEG) count_next = count - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  `DWSC_ASSERT_NEXT(a_clear_zero, ctl.clear, (count == '0))
  `DWSC_ASSERT_NOW(a_count_range, 1'b1, (count != {1'b1, {(COUNT_BITS-1){1'b0}}}))

endmodule

@@ sv/dwsc_pd_wheel.sv @@
// ----------------------------------------------------------------------------
// dwsc_pd_wheel
// Incremental PD update and saturating drive accumulator of one wheel
// ----------------------------------------------------------------------------
`include "dual_wheel_encoder_pd_speed_control_macros.svh"

module dwsc_pd_wheel #(
  parameter int COUNT_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         update,
  input  logic signed [COUNT_BITS-1:0] count,
  input  logic signed [15:0]           setpoint,
  input  logic [15:0]                  gain_p,
  input  logic [15:0]                  gain_d,
  output logic [7:0]                   pwm_next,
  output logic                         reverse_next
);
  import dwsc_pkg::*;

  localparam int SPAN   = (COUNT_BITS + 8 > 16) ? COUNT_BITS + 8 : 16;
  localparam int ERR_W  = SPAN + 2;
  localparam int DIFF_W = ERR_W + 1;
  localparam int PP_W   = ERR_W + 17;
  localparam int PD_W   = DIFF_W + 17;
  localparam int SUM_W  = PD_W + 1;
  localparam int INC_W  = SUM_W - 12;
  localparam int NEXT_W = INC_W + 1;

  logic signed [ERR_W-1:0]  prev_err;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ERR_W-1:0]  count_q88;
  logic signed [ERR_W-1:0]  err;
  logic signed [DIFF_W-1:0] diff;
  logic signed [16:0]       gp_s;
  logic signed [16:0]       gd_s;
  logic signed [PP_W-1:0]   prod_p;
  logic signed [PD_W-1:0]   prod_d;
  logic signed [SUM_W-1:0]  sum;
  logic signed [INC_W-1:0]  inc;
  logic signed [NEXT_W-1:0] acc_sum;
  logic signed [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]         mag;

  // error in Q8.8 and its decrease since the last tick
  assign count_q88 = {{(ERR_W-COUNT_BITS-8){count[COUNT_BITS-1]}}, count, 8'b0};
  assign err       = ERR_W'(setpoint) - count_q88;
  assign diff      = DIFF_W'(prev_err) - DIFF_W'(err);

  // PD terms in Q.20, floor shift back to Q8.8
  assign gp_s   = {1'b0, gain_p};
  assign gd_s   = {1'b0, gain_d};
  assign prod_p = gp_s * err;
  assign prod_d = gd_s * diff;
  assign sum    = SUM_W'(prod_p) + SUM_W'(prod_d);
  assign inc    = sum[SUM_W-1:12];

  // accumulate and clamp to the drive range
  assign acc_sum = NEXT_W'(inc) + NEXT_W'(acc);
  always_comb begin
    priority if (acc_sum > NEXT_W'(DRIVE_LIMIT)) begin
      acc_next = ACC_W'(DRIVE_LIMIT);
    end else if (acc_sum < -NEXT_W'(DRIVE_LIMIT)) begin
      acc_next = -ACC_W'(DRIVE_LIMIT);
    end else begin
      acc_next = acc_sum[ACC_W-1:0];
    end
  end

  // magnitude and direction of the new drive
  assign mag          = acc_next[ACC_W-1] ? ACC_W'(-acc_next) : acc_next;
  assign pwm_next     = mag[15:8];
  assign reverse_next = acc_next[ACC_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= '0;
      acc      <= '0;
    end else if (update) begin
      prev_err <= err;
      acc      <= acc_next;
    end
  end

  `DWSC_ASSERT_NOW(a_acc_high, 1'b1, acc <= ACC_W'(DRIVE_LIMIT))
  `DWSC_ASSERT_NOW(a_acc_low, 1'b1, acc >= -ACC_W'(DRIVE_LIMIT))
  `DWSC_ASSERT_NEXT(a_err_taken, update, prev_err == $past(err))

endmodule

@@ sv/dual_wheel_encoder_pd_speed_control.sv @@
// ----------------------------------------------------------------------------
// dual_wheel_encoder_pd_speed_control
// Two encoder edge counters feeding per-wheel incremental PD speed loops
// ----------------------------------------------------------------------------
// channel  dir  kind        contents
// s_*      in   stream      tuser: req_type; tdata: enc_a, enc_b
// m_*      out  stream      tdata: left_pwm, left_reverse, right_pwm, right_reverse
// cfg_*    in   write port  gain_p, gain_d, setpoint_left, setpoint_right
//
// one item per cycle while no tick is held back; an item is registered in the input register and a tick
// result is registered from there into the output register
// the PD multiply, accumulate and clamp of both wheels run combinationally ahead of the output register
// reset is synchronous and needs no clearing pass
// only a tick stalls the input register, while a result still waits on m_tready
// ----------------------------------------------------------------------------
`include "dual_wheel_encoder_pd_speed_control_macros.svh"

module dual_wheel_encoder_pd_speed_control #(
  parameter int COUNT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [7:0]                        s_tdata,  // [0] enc_a, [1] enc_b
  input  logic [1:0]                        s_tuser,  // [1:0] req_type
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [7:0] left_pwm, [8] left_reverse, [16:9] right_pwm, [17] right_reverse
  output logic [23:0]                       m_tdata,
  input  logic                              cfg_wr_en,
  input  logic [dwsc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dwsc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dwsc_pkg::*;

  logic [15:0]        gain_p;
  logic [15:0]        gain_d;
  logic signed [15:0] setpoint_left;
  logic signed [15:0] setpoint_right;

  logic       stage_valid;
  logic [1:0] stage_req;
  logic       stage_same;
  logic       slot_free;
  logic       advance;
  logic       tick;

  edge_ctl_t                    left_ctl;
  edge_ctl_t                    right_ctl;
  logic signed [COUNT_BITS-1:0] left_count;
  logic signed [COUNT_BITS-1:0] right_count;
  logic [7:0]                   left_pwm_next;
  logic [7:0]                   right_pwm_next;
  logic                         left_rev_next;
  logic                         right_rev_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p         <= 16'd4096;
      gain_d         <= 16'd4096;
      setpoint_left  <= '0;
      setpoint_right <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_GAIN_P:    gain_p         <= cfg_wdata;
        REG_GAIN_D:    gain_d         <= cfg_wdata;
        REG_SET_LEFT:  setpoint_left  <= cfg_wdata;
        REG_SET_RIGHT: setpoint_right <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register; edges always move on, a tick waits for the output slot
  assign slot_free = !m_tvalid || m_tready;
  assign tick      = stage_req == REQ_TICK;
  assign advance   = stage_valid && (!tick || slot_free);
  assign s_tready  = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (s_tready) begin
      stage_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stage_req  <= s_tuser;
      stage_same <= s_tdata[0] == s_tdata[1];
    end
  end

  // edge counter control: left counts down on equal levels, right counts up
  assign left_ctl.step   = advance && stage_req == REQ_LEFT_EDGE;
  assign left_ctl.up     = !stage_same;
  assign left_ctl.clear  = advance && tick;
  assign right_ctl.step  = advance && stage_req == REQ_RIGHT_EDGE;
  assign right_ctl.up    = stage_same;
  assign right_ctl.clear = advance && tick;

  dwsc_edge_counter #(.COUNT_BITS(COUNT_BITS)) u_left_count (
    .clk   (clk),
    .rst   (rst),
    .ctl   (left_ctl),
    .count (left_count)
  );

  dwsc_edge_counter #(.COUNT_BITS(COUNT_BITS)) u_right_count (
    .clk   (clk),
    .rst   (rst),
    .ctl   (right_ctl),
    .count (right_count)
  );

  // per-wheel PD loops
  dwsc_pd_wheel #(.COUNT_BITS(COUNT_BITS)) u_left_pd (
    .clk          (clk),
    .rst          (rst),
    .update       (advance && tick),
    .count        (left_count),
    .setpoint     (setpoint_left),
    .gain_p       (gain_p),
    .gain_d       (gain_d),
    .pwm_next     (left_pwm_next),
    .reverse_next (left_rev_next)
  );

  dwsc_pd_wheel #(.COUNT_BITS(COUNT_BITS)) u_right_pd (
    .clk          (clk),
    .rst          (rst),
    .update       (advance && tick),
    .count        (right_count),
    .setpoint     (setpoint_right),
    .gain_p       (gain_p),
    .gain_d       (gain_d),
    .pwm_next     (right_pwm_next),
    .reverse_next (right_rev_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && tick) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick) begin
      m_tdata <= {6'b0, right_rev_next, right_pwm_next, left_rev_next, left_pwm_next};
    end
  end

  `DWSC_ASSERT_NEXT(a_tick_result, advance && tick, m_tvalid)
  `DWSC_ASSERT_NEXT(a_tick_held, stage_valid && tick && !slot_free,
                    stage_valid && stage_req == REQ_TICK)
  `DWSC_ASSERT_NOW(a_edge_no_stall, stage_valid && !tick, advance && s_tready)

endmodule
